>>> hdl/bes_pkg.sv
package bes_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef logic signed [31:0] elem_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_DOWN,
    CMD_UP
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ALIGN,
    ST_DRAIN
  } state_t;

endpackage

>>> hdl/bes_cell.sv
module bes_cell (
  input  logic                clk,
  input  bes_pkg::cell_cmd_t  cmd,
  input  bes_pkg::elem_t      ins_value,
  input  logic                occupied,
  input  bes_pkg::elem_t      below_value,
  input  logic                below_lt,
  input  bes_pkg::elem_t      above_value,
  output bes_pkg::elem_t      value,
  output logic                lt
);

  // An empty cell counts as larger than anything, so the chain stays monotone.
  assign lt = !occupied || (ins_value < value);

  always_ff @(posedge clk) begin
    case (cmd)
      bes_pkg::CMD_INSERT: begin
        // take the lower neighbor when it also gives way, else the new item
        if (lt) begin
          value <= below_lt ? below_value : ins_value;
        end
      end
      bes_pkg::CMD_DOWN: value <= above_value;
      bes_pkg::CMD_UP:   value <= below_value;
      default:           value <= value;
    endcase
  end

endmodule

>>> hdl/bidirectional_exchange_sort_top.sv
// Channel  | Handshake              | Payload
// ---------+------------------------+----------------------------------
// in       | in_valid / in_stall    | value, last_in
// out      | out_valid / out_stall  | sorted_value, last_out, overflow
// cfg      | cfg_we (no wait)       | cfg_wdata (descending)
//
// Each item is inserted, while the chain has room, into an ascending
// chain of MAX_ITEMS cells in the cycle it is accepted.
// After the final item, results leave one per cycle while out_stall allows,
// from the bottom cell (ascending) or the top cell (descending); a
// descending batch of under MAX_ITEMS items first shifts up to the top cell.
// in_stall is high from the final item until the last result is registered.
// Reset clears the counters, the flags and the output valid bit; the cells
// need no clearing, since the fill count marks which of them hold data.
module bidirectional_exchange_sort_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bes_pkg::elem_t        value,
  input  logic                  last_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bes_pkg::elem_t        sorted_value,
  output logic                  last_out,
  output logic                  overflow
);

  localparam int N = bes_pkg::MAX_ITEMS;
  localparam int W = bes_pkg::CNT_W;

  // Configuration register: direction of the sort.
  logic descending;
  logic desc_lat;

  // Control state.
  bes_pkg::state_t    state, state_next;
  logic [W-1:0]       count, count_next;
  logic [W-1:0]       remain, remain_next;
  logic               ovf, ovf_next;
  logic               desc_lat_next;
  bes_pkg::cell_cmd_t cmd;

  // Chain wiring.
  bes_pkg::elem_t cell_value [N];
  logic           cell_lt    [N];

  logic in_acc;
  logic can_emit;
  logic room;
  logic [W-1:0] count_ins;

  assign in_acc    = in_valid && !in_stall;
  assign can_emit  = !out_valid || !out_stall;
  assign room      = count < W'(N);
  assign count_ins = room ? count + W'(1) : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
    end else if (cfg_we) begin
      descending <= cfg_wdata;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      bes_pkg::ST_LOAD: begin
        if (in_acc && last_in) begin
          state_next = (descending && count_ins != W'(N)) ? bes_pkg::ST_ALIGN
                                                          : bes_pkg::ST_DRAIN;
        end
      end
      bes_pkg::ST_ALIGN: begin
        if (count == W'(N - 1)) begin
          state_next = bes_pkg::ST_DRAIN;
        end
      end
      bes_pkg::ST_DRAIN: begin
        if (can_emit && remain == W'(1)) begin
          state_next = bes_pkg::ST_LOAD;
        end
      end
      default: state_next = bes_pkg::ST_LOAD;
    endcase
  end

  // Outputs of the state machine: chain command and input stall.
  always_comb begin
    cmd      = bes_pkg::CMD_HOLD;
    in_stall = 1'b1;
    case (state)
      bes_pkg::ST_LOAD: begin
        in_stall = 1'b0;
        // drop the item when the chain is full
        if (in_acc && room) begin
          cmd = bes_pkg::CMD_INSERT;
        end
      end
      bes_pkg::ST_ALIGN: cmd = bes_pkg::CMD_UP;
      bes_pkg::ST_DRAIN: begin
        if (can_emit) begin
          cmd = desc_lat ? bes_pkg::CMD_UP : bes_pkg::CMD_DOWN;
        end
      end
      default: cmd = bes_pkg::CMD_HOLD;
    endcase
  end

  // Counters and flags.
  always_comb begin
    count_next    = count;
    remain_next   = remain;
    ovf_next      = ovf;
    desc_lat_next = desc_lat;
    case (state)
      bes_pkg::ST_LOAD: begin
        if (in_acc) begin
          count_next = count_ins;
          if (!room) begin
            ovf_next = 1'b1;
          end
          if (last_in) begin
            remain_next   = count_ins;
            desc_lat_next = descending;
          end
        end
      end
      // count tracks how far the top item has climbed
      bes_pkg::ST_ALIGN: count_next = count + W'(1);
      bes_pkg::ST_DRAIN: begin
        if (can_emit) begin
          remain_next = remain - W'(1);
          if (remain == W'(1)) begin
            count_next = '0;
            ovf_next   = 1'b0;
          end
        end
      end
      default: count_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bes_pkg::ST_LOAD;
      count    <= '0;
      remain   <= '0;
      ovf      <= 1'b0;
      desc_lat <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      remain   <= remain_next;
      ovf      <= ovf_next;
      desc_lat <= desc_lat_next;
    end
  end

  // Output register: in drain, load a result whenever the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == bes_pkg::ST_DRAIN && can_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bes_pkg::ST_DRAIN && can_emit) begin
      sorted_value <= desc_lat ? cell_value[N-1] : cell_value[0];
      last_out     <= remain == W'(1);
      overflow     <= ovf;
    end
  end

  // Chain of cells, smallest item at the bottom.
  for (genvar i = 0; i < N; i++) begin : g_cell
    bes_pkg::elem_t below_v;
    bes_pkg::elem_t above_v;
    logic           below_l;

    if (i == 0) begin : g_bot
      assign below_v = '0;
      assign below_l = 1'b0;
    end else begin : g_mid
      assign below_v = cell_value[i-1];
      assign below_l = cell_lt[i-1];
    end

    if (i == N - 1) begin : g_top
      assign above_v = '0;
    end else begin : g_low
      assign above_v = cell_value[i+1];
    end

    bes_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .ins_value   (value),
      .occupied    (W'(i) < count),
      .below_value (below_v),
      .below_lt    (below_l),
      .above_value (above_v),
      .value       (cell_value[i]),
      .lt          (cell_lt[i])
    );
  end

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == bes_pkg::ST_DRAIN |-> remain != '0)
    else $error("drain with no items left");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= W'(N))
    else $error("fill count beyond chain length");

  a_align_bound: assert property (@(posedge clk) disable iff (rst)
    state == bes_pkg::ST_ALIGN |-> count < W'(N))
    else $error("align past top of chain");

  a_final_result: assert property (@(posedge clk) disable iff (rst)
    (state == bes_pkg::ST_DRAIN && can_emit && remain == W'(1))
    |=> (state == bes_pkg::ST_LOAD && out_valid && last_out && count == '0))
    else $error("final result not marked or batch not closed");

endmodule
